FILE: src/krt_pkg.sv
package krt_pkg;

    localparam int DEPTH_DEFAULT = 64;

    localparam logic [2:0] OP_INSERT = 3'd0;
    localparam logic [2:0] OP_LOOKUP = 3'd1;
    localparam logic [2:0] OP_ADJ_QTY = 3'd2;
    localparam logic [2:0] OP_ADJ_PRICE = 3'd3;
    localparam logic [2:0] OP_LIST = 3'd4;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_NOT_FOUND = 3'd1;
    localparam logic [2:0] ST_EXISTS = 3'd2;
    localparam logic [2:0] ST_FULL = 3'd3;
    localparam logic [2:0] ST_EMPTY = 3'd4;

    typedef struct packed {
        logic [15:0] key;
        logic signed [31:0] qty;
        logic signed [31:0] price;
    } record_t;

    typedef struct packed {
        logic [2:0] status;
        logic [15:0] key;
        logic signed [31:0] qty;
        logic signed [31:0] price;
        logic last;
    } result_t;

    // Exact 33-bit sum of two signed words, clamped to the signed 32-bit range.
    function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [32:0] s;
        s = 33'(a) + 33'(b);
        if (s[32] != s[31])
        begin
            sat_add = s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        else
        begin
            sat_add = s[31:0];
        end
    endfunction

endpackage

FILE: src/krt_mem.sv
module krt_mem #(
    parameter int DEPTH = krt_pkg::DEPTH_DEFAULT,
    parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                    clk,
    input  logic                    we,
    input  logic [AW-1:0]           waddr,
    input  krt_pkg::record_t        wdata,
    input  logic [AW-1:0]           raddr,
    output krt_pkg::record_t        rdata
);
    import krt_pkg::*;

    record_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: src/krt_ctrl.sv
module krt_ctrl #(
    parameter int DEPTH = krt_pkg::DEPTH_DEFAULT,
    parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    parameter int CW = $clog2(DEPTH + 1)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [2:0]        op,
    input  logic [15:0]       key,
    input  logic signed [31:0] iqty,
    input  logic signed [31:0] iprice,
    input  logic signed [31:0] dqty,
    input  logic signed [31:0] dprice,
    output logic              res_valid,
    input  logic              res_ready,
    output krt_pkg::result_t  res,
    output logic              we,
    output logic [AW-1:0]     waddr,
    output krt_pkg::record_t  wdata,
    output logic [AW-1:0]     raddr,
    input  krt_pkg::record_t  rdata
);
    import krt_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SCAN   = 4'd1;  // linear key search
    localparam logic [3:0] S_FOUND  = 4'd2;  // modify and write back
    localparam logic [3:0] S_OUT    = 4'd3;  // hold result until taken
    localparam logic [3:0] S_SORTI  = 4'd4;  // read element i
    localparam logic [3:0] S_SORTK  = 4'd5;  // capture element i, read j-1
    localparam logic [3:0] S_SORTC  = 4'd6;  // compare j-1 with held record
    localparam logic [3:0] S_LREAD  = 4'd7;  // list: read entry
    localparam logic [3:0] S_LWAIT  = 4'd8;  // list: present entry

    logic [3:0]        state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     idx_reg, idx_next;    // scan / outer sort / list index
    logic [CW-1:0]     j_reg, j_next;        // inner sort position
    logic [2:0]        op_reg, op_next;
    logic [15:0]       key_reg, key_next;
    logic signed [31:0] a_reg, a_next, b_reg, b_next;
    record_t           hold_reg, hold_next;
    result_t           res_reg, res_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_OUT) || (state_reg == S_LWAIT);
    assign res = res_reg;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next = idx_reg;
        j_next = j_reg;
        op_next = op_reg;
        key_next = key_reg;
        a_next = a_reg;
        b_next = b_reg;
        hold_next = hold_reg;
        res_next = res_reg;
        we = 1'b0;
        waddr = idx_reg[AW-1:0];
        wdata = rdata;
        raddr = idx_reg[AW-1:0];
        case (state_reg)
            S_IDLE:
            begin
                raddr = '0;
                idx_next = '0;
                if (in_valid)
                begin
                    op_next = op;
                    key_next = key;
                    a_next = (op == OP_INSERT) ? iqty : dqty;
                    b_next = (op == OP_INSERT) ? iprice : dprice;
                    res_next = '0;
                    res_next.last = 1'b1;
                    if (op == OP_LIST)
                    begin
                        if (count_reg == '0)
                        begin
                            res_next.status = ST_EMPTY;
                            state_next = S_OUT;
                        end
                        else
                        begin
                            idx_next = CW'(1);
                            state_next = S_SORTI;
                        end
                    end
                    else if (op == OP_INSERT && count_reg == CW'(DEPTH))
                    begin
                        res_next.status = ST_FULL;
                        state_next = S_OUT;
                    end
                    else if (op == OP_INSERT || op == OP_LOOKUP || op == OP_ADJ_QTY ||
                             op == OP_ADJ_PRICE)
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                // rdata holds entry idx_reg when idx_reg < count.
                if (idx_reg >= count_reg)
                begin
                    if (op_reg == OP_INSERT)
                    begin
                        we = 1'b1;
                        waddr = count_reg[AW-1:0];
                        wdata = '{key: key_reg, qty: a_reg, price: b_reg};
                        count_next = count_reg + CW'(1);
                        res_next = '{status: ST_OK, key: key_reg, qty: a_reg,
                                     price: b_reg, last: 1'b1};
                    end
                    else
                    begin
                        res_next.status = ST_NOT_FOUND;
                    end
                    state_next = S_OUT;
                end
                else if (rdata.key == key_reg)
                begin
                    if (op_reg == OP_INSERT)
                    begin
                        res_next.status = ST_EXISTS;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        hold_next = rdata;
                        state_next = S_FOUND;
                    end
                end
                else
                begin
                    idx_next = idx_reg + CW'(1);
                    raddr = idx_next[AW-1:0];
                end
            end
            S_FOUND:
            begin
                wdata = hold_reg;
                if (op_reg == OP_ADJ_QTY)
                begin
                    wdata.qty = sat_add(hold_reg.qty, a_reg);
                end
                if (op_reg == OP_ADJ_PRICE)
                begin
                    wdata.price = sat_add(hold_reg.price, b_reg);
                end
                we = (op_reg != OP_LOOKUP);
                res_next = '{status: ST_OK, key: wdata.key, qty: wdata.qty,
                             price: wdata.price, last: 1'b1};
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            S_SORTI:
            begin
                if (idx_reg >= count_reg)
                begin
                    idx_next = '0;
                    raddr = '0;
                    state_next = S_LREAD;
                end
                else
                begin
                    raddr = idx_reg[AW-1:0];
                    j_next = idx_reg;
                    state_next = S_SORTK;
                end
            end
            S_SORTK:
            begin
                hold_next = rdata;
                raddr = AW'(j_reg - CW'(1));
                state_next = S_SORTC;
            end
            S_SORTC:
            begin
                // rdata is entry j-1; shift it up while it is larger.
                if (j_reg != '0 && rdata.key > hold_reg.key)
                begin
                    we = 1'b1;
                    waddr = j_reg[AW-1:0];
                    wdata = rdata;
                    j_next = j_reg - CW'(1);
                    raddr = AW'(j_reg - CW'(2));
                end
                else
                begin
                    we = 1'b1;
                    waddr = j_reg[AW-1:0];
                    wdata = hold_reg;
                    idx_next = idx_reg + CW'(1);
                    state_next = S_SORTI;
                end
            end
            S_LREAD:
            begin
                res_next = '{status: ST_OK, key: rdata.key, qty: rdata.qty,
                             price: rdata.price,
                             last: (idx_reg + CW'(1) == count_reg)};
                state_next = S_LWAIT;
            end
            S_LWAIT:
            begin
                raddr = AW'(idx_reg + CW'(1));
                if (res_ready)
                begin
                    if (res_reg.last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + CW'(1);
                        state_next = S_LREAD;
                    end
                end
                else
                begin
                    raddr = idx_reg[AW-1:0];
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        j_reg <= j_next;
        op_reg <= op_next;
        key_reg <= key_next;
        a_reg <= a_next;
        b_reg <= b_next;
        hold_reg <= hold_next;
        res_reg <= res_next;
    end
endmodule

FILE: src/keyed_record_table.sv
// Keyed record table: up to TABLE_DEPTH records, each a unique 16-bit part
// number with a signed quantity and a signed price in cents, held in one
// single-port-write, registered-read memory. One request is handled at a
// time. Insert, lookup and both adjust operations scan the table linearly,
// one entry per cycle, and then hold the result until it is taken; an insert
// into a full table is refused without a scan. List first sorts the table in
// place by insertion sort, ascending by key, then emits one result per record,
// reading the next record only after the last one has been taken.
module keyed_record_table #(
    parameter int TABLE_DEPTH = krt_pkg::DEPTH_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata, low bit first: opcode[2:0], part_key[18:3], initial_quantity[50:19],
    // initial_price[82:51], quantity_delta[114:83], price_delta[146:115], zero pad.
    input  logic [151:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata, low bit first: status[2:0], record_key[18:3], record_quantity[50:19],
    // record_price[82:51], zero pad.
    output logic [87:0]  m_axis_tdata,
    output logic         m_axis_tlast
);
    import krt_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    record_t       wdata, rdata;
    result_t       res;

    krt_mem #(.DEPTH(TABLE_DEPTH)) u_mem (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    krt_ctrl #(.DEPTH(TABLE_DEPTH)) u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .op(s_axis_tdata[2:0]), .key(s_axis_tdata[18:3]),
        .iqty(s_axis_tdata[50:19]), .iprice(s_axis_tdata[82:51]),
        .dqty(s_axis_tdata[114:83]), .dprice(s_axis_tdata[146:115]),
        .res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res(res),
        .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
    );

    assign m_axis_tdata = {5'd0, res.price, res.qty, res.key, res.status};
    assign m_axis_tlast = res.last;
endmodule

FILE: src/krt_checker.sv
module krt_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [87:0]  m_axis_tdata,
    input logic         m_axis_tlast
);
    import krt_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input taken while a result is pending");

    a_nokey: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[2:0] != ST_OK |-> m_axis_tdata[82:3] == '0
        && m_axis_tlast)
        else $error("error result carries a record");

    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[2:0] <= ST_EMPTY)
        else $error("bad status code");
endmodule

bind keyed_record_table krt_checker u_chk (.*);
